// ----- design/gzip_header_parser_assert.svh -----
// Assertion macros used by the parser core module.
// Each one is compiled out when SYNTHESIS is defined.
`ifndef GZIP_HEADER_PARSER_ASSERT_SVH
`define GZIP_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk while rstn is high.
`define GZHP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gzhp assertion failed");
// Check that cond never holds while rstn is high.
`define GZHP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("gzhp forbidden condition seen");
`else
`define GZHP_ASSERT(lbl, clk, rstn, prop)
`define GZHP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- design/gzhp_pkg.sv -----
package gzhp_pkg;

  // Width of the internal byte counter; reported offsets are always 16 bits.
  localparam int OffsetBits = 16;
  localparam int ClipBits   = (OffsetBits > 16) ? OffsetBits : 16;

  localparam logic [7:0] MagicId1 = 8'h1F;
  localparam logic [7:0] MagicId2 = 8'h8B;
  localparam int         MagicPos2 = 1;
  localparam int         FlagPos   = 3;
  localparam int         FixedLast = 9;

  // Flag byte bits
  localparam int FlagHcrc    = 1;
  localparam int FlagExtra   = 2;
  localparam int FlagName    = 3;
  localparam int FlagComment = 4;

  // Section order after the fixed header
  localparam logic [2:0] StageExtra   = 3'd0;
  localparam logic [2:0] StageName    = 3'd1;
  localparam logic [2:0] StageComment = 3'd2;
  localparam logic [2:0] StageCrc     = 3'd3;
  localparam logic [2:0] StageEnd     = 3'd4;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusBadMagic = 1'b1;

  localparam int TdataOutBits = 88;

  typedef enum logic [3:0] {
    PhIdle,
    PhFixed,
    PhXlo,
    PhXhi,
    PhXskip,
    PhName,
    PhComment,
    PhClo,
    PhChi,
    PhDone
  } phase_e;

  typedef logic [OffsetBits-1:0] pos_t;

  typedef struct packed {
    logic        status;
    logic        has_extra;
    logic [15:0] extra_offset;
    logic        has_name;
    logic [15:0] name_offset;
    logic        has_comment;
    logic [15:0] comment_offset;
    logic        has_hcrc;
    logic [15:0] header_crc;
    logic [15:0] data_offset;
  } result_t;

  // Advance the byte counter, holding at its maximum.
  function automatic pos_t next_pos(pos_t p);
    return (p == {OffsetBits{1'b1}}) ? p : p + 1'b1;
  endfunction

  // Report a counter value on 16 bits, saturating above 65535.
  function automatic logic [15:0] clip_offset(pos_t v);
    logic [ClipBits-1:0] w;
    w = ClipBits'(v);
    if (w > ClipBits'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

// ----- design/gzhp_core.sv -----
`include "gzip_header_parser_assert.svh"

module gzhp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_i,
  output logic              res_valid_o,
  output gzhp_pkg::result_t res_o
);

  gzhp_pkg::phase_e phase_q, phase_d;
  gzhp_pkg::pos_t   pos_q, pos_d;
  logic [4:1]       flags_q, flags_d;
  logic [15:0]      skip_q, skip_d;
  logic [7:0]       lo_q, lo_d;
  gzhp_pkg::pos_t   extra_start_q, extra_start_d;
  gzhp_pkg::pos_t   name_start_q, name_start_d;
  gzhp_pkg::pos_t   comment_start_q, comment_start_d;
  logic [15:0]      crc_q, crc_d;

  gzhp_pkg::pos_t   pos_inc;
  gzhp_pkg::pos_t   nx;
  logic             active;
  logic             start_bad;
  logic             err;
  logic             go_now;
  logic [2:0]       go_stage;
  gzhp_pkg::phase_e go_phase;
  logic             go_emit;
  logic [15:0]      word;
  logic [15:0]      skip_dec;

  assign pos_inc   = gzhp_pkg::next_pos(pos_q);
  assign nx        = gzhp_pkg::next_pos(pos_inc);
  assign word      = {data_byte_i, lo_q};
  assign skip_dec  = skip_q - 16'd1;
  assign active    = (phase_q != gzhp_pkg::PhIdle) && (phase_q != gzhp_pkg::PhDone);
  assign start_bad = first_i && (data_byte_i != gzhp_pkg::MagicId1);

  // Decode what the current byte does in the current phase.
  always_comb begin
    err      = 1'b0;
    go_now   = 1'b0;
    go_stage = gzhp_pkg::StageExtra;
    unique case (phase_q)
      gzhp_pkg::PhFixed: begin
        err    = (pos_inc == gzhp_pkg::OffsetBits'(gzhp_pkg::MagicPos2)) &&
                 (data_byte_i != gzhp_pkg::MagicId2);
        go_now = pos_inc == gzhp_pkg::OffsetBits'(gzhp_pkg::FixedLast);
      end
      gzhp_pkg::PhXhi: begin
        go_now   = word == 16'd0;
        go_stage = gzhp_pkg::StageName;
      end
      gzhp_pkg::PhXskip: begin
        go_now   = skip_dec == 16'd0;
        go_stage = gzhp_pkg::StageName;
      end
      gzhp_pkg::PhName: begin
        go_now   = data_byte_i == 8'd0;
        go_stage = gzhp_pkg::StageComment;
      end
      gzhp_pkg::PhComment: begin
        go_now   = data_byte_i == 8'd0;
        go_stage = gzhp_pkg::StageCrc;
      end
      gzhp_pkg::PhChi: begin
        go_now   = 1'b1;
        go_stage = gzhp_pkg::StageEnd;
      end
      default: begin
        go_now = 1'b0;
      end
    endcase
  end

  // Pick the next present section at or after go_stage; none left means emit.
  // The flag byte is captured well before the fixed header ends, so the
  // registered flags are already valid whenever a section change happens.
  always_comb begin
    go_emit  = 1'b0;
    go_phase = gzhp_pkg::PhDone;
    priority if (go_stage <= gzhp_pkg::StageExtra && flags_q[gzhp_pkg::FlagExtra]) begin
      go_phase = gzhp_pkg::PhXlo;
    end else if (go_stage <= gzhp_pkg::StageName && flags_q[gzhp_pkg::FlagName]) begin
      go_phase = gzhp_pkg::PhName;
    end else if (go_stage <= gzhp_pkg::StageComment &&
                 flags_q[gzhp_pkg::FlagComment]) begin
      go_phase = gzhp_pkg::PhComment;
    end else if (go_stage <= gzhp_pkg::StageCrc && flags_q[gzhp_pkg::FlagHcrc]) begin
      go_phase = gzhp_pkg::PhClo;
    end else begin
      go_emit = 1'b1;
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      priority if (first_i) begin
        phase_d = start_bad ? gzhp_pkg::PhDone : gzhp_pkg::PhFixed;
      end else if (!active) begin
        phase_d = phase_q;
      end else if (err) begin
        phase_d = gzhp_pkg::PhDone;
      end else if (go_now) begin
        phase_d = go_phase;
      end else begin
        unique case (phase_q)
          gzhp_pkg::PhXlo: phase_d = gzhp_pkg::PhXhi;
          gzhp_pkg::PhXhi: phase_d = gzhp_pkg::PhXskip;
          gzhp_pkg::PhClo: phase_d = gzhp_pkg::PhChi;
          default:         phase_d = phase_q;
        endcase
      end
    end
  end

  // Datapath state updates
  always_comb begin
    pos_d           = pos_q;
    flags_d         = flags_q;
    skip_d          = skip_q;
    lo_d            = lo_q;
    extra_start_d   = extra_start_q;
    name_start_d    = name_start_q;
    comment_start_d = comment_start_q;
    crc_d           = crc_q;
    if (accept_i && first_i) begin
      pos_d   = '0;
      flags_d = '0;
    end else if (accept_i && active) begin
      pos_d = pos_inc;
      unique case (phase_q)
        gzhp_pkg::PhFixed: begin
          if (pos_inc == gzhp_pkg::OffsetBits'(gzhp_pkg::FlagPos)) begin
            flags_d = data_byte_i[4:1];
          end
        end
        gzhp_pkg::PhXlo, gzhp_pkg::PhClo: lo_d = data_byte_i;
        gzhp_pkg::PhXhi:   skip_d = word;
        gzhp_pkg::PhXskip: skip_d = skip_dec;
        gzhp_pkg::PhChi:   crc_d  = word;
        default: begin
          lo_d = lo_q;
        end
      endcase
      if (go_now && !err) begin
        unique case (go_phase)
          gzhp_pkg::PhXlo:     extra_start_d   = nx;
          gzhp_pkg::PhName:    name_start_d    = nx;
          gzhp_pkg::PhComment: comment_start_d = nx;
          default:             crc_d           = crc_d;
        endcase
      end
    end
  end

  // Result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i && (start_bad || (!first_i && active && err))) begin
      res_valid_o  = 1'b1;
      res_o.status = gzhp_pkg::StatusBadMagic;
    end else if (accept_i && !first_i && active && go_now && go_emit) begin
      res_valid_o          = 1'b1;
      res_o.status         = gzhp_pkg::StatusOk;
      res_o.has_extra      = flags_q[gzhp_pkg::FlagExtra];
      res_o.extra_offset   = flags_q[gzhp_pkg::FlagExtra] ?
                             gzhp_pkg::clip_offset(extra_start_q) : 16'd0;
      res_o.has_name       = flags_q[gzhp_pkg::FlagName];
      res_o.name_offset    = flags_q[gzhp_pkg::FlagName] ?
                             gzhp_pkg::clip_offset(name_start_q) : 16'd0;
      res_o.has_comment    = flags_q[gzhp_pkg::FlagComment];
      res_o.comment_offset = flags_q[gzhp_pkg::FlagComment] ?
                             gzhp_pkg::clip_offset(comment_start_q) : 16'd0;
      res_o.has_hcrc       = flags_q[gzhp_pkg::FlagHcrc];
      res_o.header_crc     = flags_q[gzhp_pkg::FlagHcrc] ? crc_d : 16'd0;
      res_o.data_offset    = gzhp_pkg::clip_offset(nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gzhp_pkg::PhIdle;
      pos_q   <= '0;
      flags_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skip_q          <= skip_d;
    lo_q            <= lo_d;
    extra_start_q   <= extra_start_d;
    name_start_q    <= name_start_d;
    comment_start_q <= comment_start_d;
    crc_q           <= crc_d;
  end

  `GZHP_ASSERT(a_result_ends_parse, clk_i, rst_ni,
    res_valid_o |=> phase_q == gzhp_pkg::PhDone)
  `GZHP_ASSERT(a_error_fields_zero, clk_i, rst_ni,
    (res_valid_o && res_o.status) |-> (res_o.data_offset == 16'd0 && !res_o.has_extra))
  `GZHP_ASSERT_NEVER(a_no_result_when_idle, clk_i, rst_ni,
    accept_i && !first_i && !active && res_valid_o)
  `GZHP_ASSERT(a_pos_monotonic, clk_i, rst_ni,
    (accept_i && !first_i) |=> pos_q >= $past(pos_q))

endmodule

// ----- design/gzhp_out_reg.sv -----
module gzhp_out_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  gzhp_pkg::result_t                   res_i,
  output logic                                free_o,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [gzhp_pkg::TdataOutBits-1:0]   m_tdata_o,
  output logic                                m_tuser_o
);

  logic              valid_q, valid_d;
  gzhp_pkg::result_t res_q;

  // A held result can be replaced in the cycle it transfers.
  assign free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tuser_o  = res_q.status;
  assign m_tdata_o  = {4'd0,
                       res_q.data_offset,
                       res_q.header_crc,
                       res_q.has_hcrc,
                       res_q.comment_offset,
                       res_q.has_comment,
                       res_q.name_offset,
                       res_q.has_name,
                       res_q.extra_offset,
                       res_q.has_extra};

endmodule

// ----- design/gzip_header_parser.sv -----
// gzip member header parser.
// Input stream: one byte of a gzip member per transfer on s_tdata_i; s_tuser_i
// high marks offset 0 of a new member and restarts the parse at any time.
// Output stream: at most one result per member, issued for the byte that
// completes the header (or the byte that breaks the magic), with m_tuser_o
// giving the status (0 parsed, 1 bad magic) and m_tdata_o the section flags
// and offsets. Bytes after the result are dropped until the next first byte.
// Throughput: one byte per cycle while s_tready_o is high. The state machine and
// offset counter update in the same cycle as the transfer, and the result
// register raises m_tvalid_o in the cycle after the deciding input transfer.
// The result register decouples the two sides: s_tready_o stays high while the
// register is empty or being emptied, so input keeps flowing while a result
// waits; only a result held against a low m_tready_i stalls the input.
// Reset (rst_ni low, asynchronous) returns the parser to idle, waiting for a
// first byte, and empties the result register. No clearing pass is needed.
module gzip_header_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [7:0]                        s_tdata_i,  // [7:0] data_byte
  input  logic                              s_tuser_i,  // [0] first
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // [0] has_extra, [16:1] extra_offset, [17] has_name, [33:18] name_offset,
  // [34] has_comment, [50:35] comment_offset, [51] has_hcrc,
  // [67:52] header_crc, [83:68] data_offset, [87:84] zero
  output logic [gzhp_pkg::TdataOutBits-1:0] m_tdata_o,
  output logic                              m_tuser_o   // [0] status
);

  logic              accept;
  logic              free;
  logic              res_valid;
  gzhp_pkg::result_t res;

  assign s_tready_o = free;
  assign accept     = s_tvalid_i && free;

  gzhp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_tdata_i),
    .first_i     (s_tuser_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  gzhp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .free_o     (free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

// ----- test/gzip_header_parser_tb.sv -----
module gzip_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gzhp_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int TailCycles = 32;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } in_item_t;

  typedef enum logic [1:0] {
    RdyOpen,
    RdyCoin,
    RdySparse
  } rdy_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [7:0] s_tdata_i = 8'h00;  // [7:0] data_byte
  logic s_tuser_i = 1'b0;         // [0] first
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  // [0] has_extra, [16:1] extra_offset, [17] has_name, [33:18] name_offset,
  // [34] has_comment, [50:35] comment_offset, [51] has_hcrc,
  // [67:52] header_crc, [83:68] data_offset, [87:84] zero
  logic [TdataOutBits-1:0] m_tdata_o;
  logic m_tuser_o;                // [0] status

  gzip_header_parser dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  in_item_t member_bytes[$];
  result_t  pending_headers[$];

  bit in_flight = 1'b0;
  int err_count = 0;
  int bytes_sent = 0;
  int headers_checked = 0;
  int bad_magic_seen = 0;
  int saturated_seen = 0;
  int cycle_count = 0;

  // Parser state mirrored on the testbench side
  phase_e      sec_phase = PhIdle;
  pos_t        hdr_pos = '0;
  logic [7:0]  flag_byte = '0;
  logic [15:0] skip_left = '0;
  logic [7:0]  low_hold = '0;
  pos_t        extra_at = '0;
  pos_t        name_at = '0;
  pos_t        comment_at = '0;
  logic [15:0] crc_word = '0;

  function automatic pos_t step_count(pos_t p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  function automatic logic [15:0] report16(pos_t v);
    if (OffsetBits > 16 && v > pos_t'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  task automatic mark_bad_magic(output bit got, output result_t res);
    got = 1'b1;
    res = '0;
    res.status = StatusBadMagic;
    sec_phase = PhDone;
  endtask

  // Open the next present section from stage on, or finish the header.
  task automatic enter_section(input int stage, output bit got, output result_t res);
    pos_t nx;
    nx = step_count(hdr_pos);
    got = 1'b0;
    res = '0;
    if (stage <= int'(StageExtra) && flag_byte[FlagExtra]) begin
      extra_at = nx;
      sec_phase = PhXlo;
    end else if (stage <= int'(StageName) && flag_byte[FlagName]) begin
      name_at = nx;
      sec_phase = PhName;
    end else if (stage <= int'(StageComment) && flag_byte[FlagComment]) begin
      comment_at = nx;
      sec_phase = PhComment;
    end else if (stage <= int'(StageCrc) && flag_byte[FlagHcrc]) begin
      sec_phase = PhClo;
    end else begin
      got = 1'b1;
      res.status = StatusOk;
      res.has_extra = flag_byte[FlagExtra];
      res.extra_offset = flag_byte[FlagExtra] ? report16(extra_at) : 16'h0;
      res.has_name = flag_byte[FlagName];
      res.name_offset = flag_byte[FlagName] ? report16(name_at) : 16'h0;
      res.has_comment = flag_byte[FlagComment];
      res.comment_offset = flag_byte[FlagComment] ? report16(comment_at) : 16'h0;
      res.has_hcrc = flag_byte[FlagHcrc];
      res.header_crc = flag_byte[FlagHcrc] ? crc_word : 16'h0;
      res.data_offset = report16(nx);
      sec_phase = PhDone;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic f,
                            output bit got, output result_t res);
    got = 1'b0;
    res = '0;
    if (f) begin
      hdr_pos = '0;
      flag_byte = '0;
      skip_left = '0;
      low_hold = '0;
      extra_at = '0;
      name_at = '0;
      comment_at = '0;
      crc_word = '0;
      if (b != MagicId1) begin
        mark_bad_magic(got, res);
      end else begin
        sec_phase = PhFixed;
      end
    end else if (sec_phase != PhIdle && sec_phase != PhDone) begin
      hdr_pos = step_count(hdr_pos);
      case (sec_phase)
        PhFixed: begin
          if (hdr_pos == pos_t'(MagicPos2) && b != MagicId2) begin
            mark_bad_magic(got, res);
          end else begin
            if (hdr_pos == pos_t'(FlagPos)) flag_byte = b;
            if (hdr_pos == pos_t'(FixedLast)) enter_section(StageExtra, got, res);
          end
        end
        PhXlo: begin
          low_hold = b;
          sec_phase = PhXhi;
        end
        PhXhi: begin
          skip_left = {b, low_hold};
          if (skip_left == 16'h0) enter_section(StageName, got, res);
          else sec_phase = PhXskip;
        end
        PhXskip: begin
          skip_left = skip_left - 16'h1;
          if (skip_left == 16'h0) enter_section(StageName, got, res);
        end
        PhName: begin
          if (b == 8'h00) enter_section(StageComment, got, res);
        end
        PhComment: begin
          if (b == 8'h00) enter_section(StageCrc, got, res);
        end
        PhClo: begin
          low_hold = b;
          sec_phase = PhChi;
        end
        PhChi: begin
          crc_word = {b, low_hold};
          enter_section(StageEnd, got, res);
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0h, actual %0h", fname, want, seen);
      err_count++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic f);
    member_bytes.push_back('{first: f, data: b});
  endtask

  // Queue one member: mostly well-formed, some with bad magic, some cut short.
  task automatic add_member(input bit long_hdr);
    logic [7:0] hdr[$];
    logic [7:0] flg;
    logic [7:0] b;
    int xlen;
    int nlen;
    int cut;
    int k;
    if (!long_hdr && $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        b = 8'($urandom);
        if (b == MagicId1) b = ~b;
        hdr.push_back(b);
      end else begin
        b = 8'($urandom);
        if (b == MagicId2) b = ~b;
        hdr.push_back(MagicId1);
        hdr.push_back(b);
      end
    end else begin
      hdr.push_back(MagicId1);
      hdr.push_back(MagicId2);
      hdr.push_back(($urandom_range(0, 1) == 0) ? 8'h08 : 8'($urandom));
      flg = 8'($urandom);
      if (long_hdr) flg[FlagExtra] = 1'b1;
      hdr.push_back(flg);
      repeat (6) hdr.push_back(8'($urandom));
      if (flg[FlagExtra]) begin
        if (long_hdr) xlen = $urandom_range(16'hFF00, 16'hFFFF);
        else if ($urandom_range(0, 3) == 0) xlen = 0;
        else xlen = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6);
        hdr.push_back(xlen[7:0]);
        hdr.push_back(xlen[15:8]);
        repeat (xlen) hdr.push_back(8'($urandom));
      end
      if (flg[FlagName]) begin
        nlen = $urandom_range(0, 10);
        repeat (nlen) hdr.push_back(8'($urandom_range(1, 255)));
        hdr.push_back(8'h00);
      end
      if (flg[FlagComment]) begin
        nlen = $urandom_range(0, 10);
        repeat (nlen) hdr.push_back(8'($urandom_range(1, 255)));
        hdr.push_back(8'h00);
      end
      if (flg[FlagHcrc]) begin
        hdr.push_back(8'($urandom));
        hdr.push_back(8'($urandom));
      end
      if (!long_hdr && $urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, hdr.size() - 1);
        while (hdr.size() > cut) void'(hdr.pop_back());
      end
    end
    // compressed data after the header is dropped by the parser
    repeat ($urandom_range(0, 5)) hdr.push_back(8'($urandom));
    for (k = 0; k < hdr.size(); k++) push_byte(hdr[k], k == 0);
  endtask

  // Sender: bursts of transfers separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk_i) begin
    in_item_t item;
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (!in_flight) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid_i <= 1'b0;
      end else if (member_bytes.size() > 0) begin
        item = member_bytes.pop_front();
        s_tdata_i <= item.data;
        s_tuser_i <= item.first;
        s_tvalid_i <= 1'b1;
        in_flight = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: switch between open, coin-flip and sparse ready patterns
  rdy_mode_e rdy_mode = RdyOpen;
  int rdy_left = 0;
  logic [2:0] rdy_tick = '0;

  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = rdy_mode_e'($urandom_range(0, 2));
      rdy_left = $urandom_range(32, 256);
    end else begin
      rdy_left--;
    end
    rdy_tick = rdy_tick + 3'd1;
    case (rdy_mode)
      RdyOpen: m_tready_i <= 1'b1;
      RdyCoin: m_tready_i <= 1'($urandom_range(0, 1));
      default: m_tready_i <= (rdy_tick == 3'd0);
    endcase
  end

  // Check results first, then predict from the byte taken at this edge
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    result_t res;
    bit got;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        seen = '0;
        seen.status = m_tuser_o;
        seen.has_extra = m_tdata_o[0];
        seen.extra_offset = m_tdata_o[16:1];
        seen.has_name = m_tdata_o[17];
        seen.name_offset = m_tdata_o[33:18];
        seen.has_comment = m_tdata_o[34];
        seen.comment_offset = m_tdata_o[50:35];
        seen.has_hcrc = m_tdata_o[51];
        seen.header_crc = m_tdata_o[67:52];
        seen.data_offset = m_tdata_o[83:68];
        if (pending_headers.size() == 0) begin
          $error("header result with no expectation waiting");
          err_count++;
        end else begin
          want = pending_headers.pop_front();
          check_field("status", want.status, seen.status);
          check_field("has_extra", want.has_extra, seen.has_extra);
          check_field("extra_offset", want.extra_offset, seen.extra_offset);
          check_field("has_name", want.has_name, seen.has_name);
          check_field("name_offset", want.name_offset, seen.name_offset);
          check_field("has_comment", want.has_comment, seen.has_comment);
          check_field("comment_offset", want.comment_offset, seen.comment_offset);
          check_field("has_hcrc", want.has_hcrc, seen.has_hcrc);
          check_field("header_crc", want.header_crc, seen.header_crc);
          check_field("data_offset", want.data_offset, seen.data_offset);
          headers_checked++;
          if (want.status == StatusBadMagic) bad_magic_seen++;
          if (want.data_offset == 16'hFFFF) saturated_seen++;
        end
      end
      if (s_tvalid_i && s_tready_o) begin
        in_flight = 1'b0;
        bytes_sent++;
        parse_byte(s_tdata_i, s_tuser_i, got, res);
        if (got) pending_headers.push_back(res);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int made;
    made = 0;
    // directed: stray byte while idle, bad magic at both offsets,
    // byte after a result, restart mid-header, all flags with empty strings
    push_byte(MagicId1, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(MagicId1, 1'b1);
    push_byte(8'h8A, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(MagicId1, 1'b1);
    push_byte(MagicId2, 1'b0);
    push_byte(MagicId1, 1'b1);
    push_byte(MagicId2, 1'b0);
    repeat (8) push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b0);

    while (member_bytes.size() < 1100 || made < 60) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
      add_member(1'b0);
      made++;
    end
    repeat (3) add_member(1'b0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (member_bytes.size() != 0 || in_flight || pending_headers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d header results, %0d of them bad magic.",
             bytes_sent, headers_checked, bad_magic_seen);
    $display("Results with a saturated data offset: %0d.", saturated_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
